/* sv/gcum_pkg.sv */
// ----------------------------------------------------------------------------
// gcum_pkg: shared types and constants of the grid cell union merge unit
// Field widths, sequencer states, direction and status codes, register indexes.
// ----------------------------------------------------------------------------
package gcum_pkg;

   localparam int unsigned FROM_W    = 10;
   localparam int unsigned DIR_W     = 2;
   localparam int unsigned CFG_W     = 11;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned TO_W      = 10;
   localparam int unsigned LEFT_W    = 11;
   localparam int unsigned JOIN_W    = 11;
   localparam int unsigned PROD_W    = 2 * CFG_W;
   localparam int unsigned DIV_CNT_W = $clog2(FROM_W);
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0]     CFG_RESET_VALUE = CFG_W'(32);
   localparam logic [LEFT_W-1:0]    LEFT_MAX        = '1;
   localparam logic [JOIN_W-1:0]    JOIN_MAX        = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = CSR_IDX_W'(1);

   typedef enum logic [DIR_W-1:0] {
      DIR_NORTH,
      DIR_SOUTH,
      DIR_WEST,
      DIR_EAST
   } gcum_dir_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_JOINED,
      STATUS_OFF_GRID,
      STATUS_SAME_SET
   } gcum_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_GRID,
      ST_GRID,
      ST_RANGE,
      ST_DIV,
      ST_NEIGH,
      ST_MUL_CAND,
      ST_CAND,
      ST_RD_FROM,
      ST_RD_TO,
      ST_CMP,
      ST_SCAN,
      ST_SCAN_END,
      ST_DONE
   } gcum_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } gcum_div_stat_type;

endpackage

/* sv/gcum_channels.sv */
// ----------------------------------------------------------------------------
// gcum channels: request and response valid/ready interfaces
// Request beat carries a cell and a direction, response beat the outcome.
// ----------------------------------------------------------------------------
interface gcum_req_if import gcum_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FROM_W-1:0] from_cell;
   logic [DIR_W-1:0]  direction;

   modport source (output valid, output from_cell, output direction, input ready);
   modport sink   (input valid, input from_cell, input direction, output ready);
endinterface

interface gcum_rsp_if import gcum_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TO_W-1:0]     to_cell;
   logic [LEFT_W-1:0]   sets_left;

   modport source (output valid, output status, output to_cell, output sets_left,
                   input ready);
   modport sink   (input valid, input status, input to_cell, input sets_left,
                   output ready);
endinterface

/* sv/gcum_div.sv */
// ----------------------------------------------------------------------------
// gcum_div: bit-serial restoring divider
// Splits a cell index into row and column, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcum_div import gcum_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FROM_W-1:0] dividend,
   input  logic [CFG_W-1:0]  divisor,
   output logic [FROM_W-1:0] quotient,
   output logic [CFG_W-1:0]  remainder,
   output gcum_div_stat_type stat
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(FROM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [FROM_W-1:0]    quo_ff, quo_in;
   logic [CFG_W-1:0]     dvs_ff, dvs_in;
   logic [CFG_W:0]       trial;
   logic [CFG_W:0]       diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[FROM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         quo_in = {quo_ff[FROM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat      = '{busy: busy_ff, done: done_ff};

endmodule

/* sv/gcum_label_mem.sv */
// ----------------------------------------------------------------------------
// gcum_label_mem: set label store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module gcum_label_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/grid_cell_union_merge_unit.sv */
// ----------------------------------------------------------------------------
// grid_cell_union_merge_unit: disjoint-set join of neighboring grid cells
// Label-based union of a cell with its neighbor in a column_count x row_count
// grid; reports status, neighbor cell and the number of sets left.
// ----------------------------------------------------------------------------
// Usage:
//   req carries from_cell and direction; rsp returns status, to_cell and
//   sets_left, one rsp beat per req beat, in order. csr_wr_en writes
//   column_count (index 0) or row_count (index 1); write only when idle.
//   A join runs the relabel scan, which visits every label entry once
//   through the single read port of the label memory. The row/column
//   split runs on a bit-serial divider, one quotient bit per cycle, and
//   then raises done.
//   One item is in work at a time; req ready is low until its result sits
//   in the rsp output register. A pending rsp beat does not block the next
//   req beat; only a finished result waits for the rsp slot to free.
//   Reset: a clearing pass writes each label with its own index; req
//   ready stays low meanwhile. Registers return to 32 x 32, join count
//   to zero.
//   Stall: a held rsp beat stays stable until rsp ready.
// ----------------------------------------------------------------------------
module grid_cell_union_merge_unit import gcum_pkg::*; #(
   parameter int unsigned MAX_CELLS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   gcum_req_if.sink             req,
   gcum_rsp_if.source           rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   localparam int unsigned AW     = $clog2(MAX_CELLS);
   localparam int unsigned CW     = $clog2(MAX_CELLS + 1);
   localparam int unsigned XW     = (AW > FROM_W) ? AW : FROM_W;
   localparam int unsigned SW     = (CW > LEFT_W) ? CW : LEFT_W;
   localparam int unsigned CAND_W = PROD_W + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

   gcum_state_type      state_ff, state_in;
   logic [CFG_W-1:0]    column_count_ff, column_count_in;
   logic [CFG_W-1:0]    row_count_ff, row_count_in;
   logic [FROM_W-1:0]   from_ff;
   gcum_dir_type        dir_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CW-1:0]       cells_ff;
   logic [CFG_W-1:0]    nrow_ff, nrow_in;
   logic [CFG_W-1:0]    ncol_ff, ncol_in;
   logic                nok_ff, nok_in;
   logic [AW-1:0]       to_ff;
   logic [AW-1:0]       lf_ff;
   logic [AW-1:0]       lt_ff;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff;
   logic [JOIN_W-1:0]   join_ff, join_in;
   gcum_status_type     res_status_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TO_W-1:0]     rsp_to_ff;
   logic [LEFT_W-1:0]   rsp_left_ff;

   logic                mul_cand;
   logic [CFG_W-1:0]    mul_a, mul_b;
   logic                div_start;
   logic [FROM_W-1:0]   div_quo;
   logic [CFG_W-1:0]    div_rem;
   gcum_div_stat_type   div_stat;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr, mem_wr_data, mem_rd_addr, mem_rd_data;
   logic                rsp_load;
   logic                req_ready;

   logic [XW-1:0]       from_wide, to_wide;
   logic [AW-1:0]       from_addr;
   logic                range_ok, neigh_ok, cand_ok, labels_equal, relabel_hit;
   logic [CAND_W-1:0]   cand;
   logic [SW-1:0]       cells_w, join_w, left_w;
   logic [LEFT_W-1:0]   left;

   gcum_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (from_ff),
      .divisor   (column_count_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   gcum_label_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_label_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // datapath conditions
   always_comb begin
      from_wide    = XW'(from_ff);
      from_addr    = from_wide[AW-1:0];
      to_wide      = XW'(to_ff);
      range_ok     = PROD_W'(from_ff) < PROD_W'(cells_ff);
      neigh_ok     = nok_ff && (nrow_ff < row_count_ff) && (ncol_ff < column_count_ff);
      cand         = CAND_W'(prod_ff) + CAND_W'(ncol_ff);
      cand_ok      = cand < CAND_W'(cells_ff);
      labels_equal = mem_rd_data == lf_ff;
      relabel_hit  = pend_ff && (mem_rd_data == lf_ff);
      mul_a        = mul_cand ? nrow_ff : column_count_ff;
      mul_b        = mul_cand ? column_count_ff : row_count_ff;
      cells_w      = SW'(cells_ff);
      join_w       = SW'(join_ff);
      left_w       = (cells_w > join_w) ? (cells_w - join_w) : '0;
      left         = (left_w > SW'(LEFT_MAX)) ? LEFT_MAX : left_w[LEFT_W-1:0];
   end

   // neighbor of the divided cell
   always_comb begin
      nrow_in = {1'b0, div_quo};
      ncol_in = div_rem;
      nok_in  = 1'b1;
      case (dir_ff)
         DIR_NORTH: begin
            nok_in  = div_quo != '0;
            nrow_in = {1'b0, div_quo} - 1'b1;
         end
         DIR_SOUTH: begin
            nrow_in = {1'b0, div_quo} + 1'b1;
         end
         DIR_WEST: begin
            nok_in  = div_rem != '0;
            ncol_in = div_rem - 1'b1;
         end
         DIR_EAST: begin
            ncol_in = div_rem + 1'b1;
         end
         default: begin
            nok_in = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (cnt_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:     if (req.valid) state_in = ST_MUL_GRID;
         ST_MUL_GRID: state_in = ST_GRID;
         ST_GRID:     state_in = ST_RANGE;
         ST_RANGE:    state_in = range_ok ? ST_DIV : ST_DONE;
         ST_DIV:      if (div_stat.done) state_in = ST_NEIGH;
         ST_NEIGH:    state_in = neigh_ok ? ST_MUL_CAND : ST_DONE;
         ST_MUL_CAND: state_in = ST_CAND;
         ST_CAND:     state_in = cand_ok ? ST_RD_FROM : ST_DONE;
         ST_RD_FROM:  state_in = ST_RD_TO;
         ST_RD_TO:    state_in = ST_CMP;
         ST_CMP:      state_in = labels_equal ? ST_DONE : ST_SCAN;
         ST_SCAN:     if (cnt_ff == LAST_ADDR) state_in = ST_SCAN_END;
         ST_SCAN_END: state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      mul_cand    = 1'b0;
      div_start   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = lt_ff;
      mem_rd_addr = cnt_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = cnt_ff;
            cnt_in      = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RANGE: begin
            div_start = range_ok;
         end
         ST_MUL_CAND: begin
            mul_cand = 1'b1;
         end
         ST_RD_FROM: begin
            mem_rd_addr = from_addr;
         end
         ST_RD_TO: begin
            mem_rd_addr = to_ff;
         end
         ST_SCAN: begin
            mem_wr_en = relabel_hit;
            pend_in   = 1'b1;
            cnt_in    = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
         end
         ST_SCAN_END: begin
            mem_wr_en = relabel_hit;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_in = csr_wr_data;
            CSR_ROW_COUNT:    row_count_in    = csr_wr_data;
            default:          column_count_in = column_count_ff;
         endcase
      end
      join_in = join_ff;
      if (state_ff == ST_SCAN_END && join_ff != JOIN_MAX) begin
         join_in = join_ff + 1'b1;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         column_count_ff <= CFG_RESET_VALUE;
         row_count_ff    <= CFG_RESET_VALUE;
         cnt_ff          <= '0;
         pend_ff         <= 1'b0;
         join_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         cnt_ff          <= cnt_in;
         pend_ff         <= pend_in;
         join_ff         <= join_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= PROD_W'(mul_a) * PROD_W'(mul_b);
      pend_addr_ff <= cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            from_ff <= req.from_cell;
            dir_ff  <= gcum_dir_type'(req.direction);
         end
         ST_GRID: begin
            cells_ff <= (prod_ff > PROD_W'(MAX_CELLS)) ? CW'(MAX_CELLS) : prod_ff[CW-1:0];
         end
         ST_RANGE: begin
            if (!range_ok) res_status_ff <= STATUS_OFF_GRID;
         end
         ST_DIV: begin
            nrow_ff <= nrow_in;
            ncol_ff <= ncol_in;
            nok_ff  <= nok_in;
         end
         ST_NEIGH: begin
            if (!neigh_ok) res_status_ff <= STATUS_OFF_GRID;
         end
         ST_CAND: begin
            to_ff <= cand[AW-1:0];
            if (!cand_ok) res_status_ff <= STATUS_OFF_GRID;
         end
         ST_RD_TO: begin
            lf_ff <= mem_rd_data;
         end
         ST_CMP: begin
            lt_ff <= mem_rd_data;
            if (labels_equal) res_status_ff <= STATUS_SAME_SET;
         end
         ST_SCAN_END: begin
            res_status_ff <= STATUS_JOINED;
         end
         default: begin
            nok_ff <= nok_ff;
         end
      endcase
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_to_ff     <= (res_status_ff == STATUS_OFF_GRID) ? '0 : to_wide[TO_W-1:0];
         rsp_left_ff   <= left;
      end
   end

   assign req.ready     = req_ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.to_cell   = rsp_to_ff;
   assign rsp.sets_left = rsp_left_ff;

   a_off_grid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == STATUS_OFF_GRID |-> rsp.to_cell == '0)
      else $error("off-grid beat with nonzero to_cell");

   a_label_write: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff == ST_CLEAR || state_ff == ST_SCAN || state_ff == ST_SCAN_END)
      else $error("label write outside clear or relabel scan");

   a_join_counted: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == STATUS_JOINED |-> join_ff != '0)
      else $error("joined beat without join count");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider done outside divide step");

endmodule
